// ===== src/text_line_normalizer_macros.svh =====
// Assertion helpers shared by the normalizer modules.
`ifndef TEXT_LINE_NORMALIZER_MACROS_SVH
`define TEXT_LINE_NORMALIZER_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define TLN_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define TLN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tln_pkg.sv =====
`default_nettype none

package tln_pkg;

  // Fixed field and state widths
  localparam int BYTE_W  = 8;
  localparam int COL_W   = 10;
  localparam int LIMIT_W = 9;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CHAR_SUB   = 8'h1A;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Register index taken from paddr[2]
  localparam logic REG_LINE_LIMIT = 1'b0;

  // Class of the held input byte
  typedef enum logic [2:0] {
    CLS_PRINT = 3'd0,
    CLS_TAB   = 3'd1,
    CLS_CR    = 3'd2,
    CLS_LF    = 3'd3,
    CLS_SUB   = 3'd4,
    CLS_CTRL  = 3'd5
  } byte_cls_t;

  // Source of an emitted character
  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_IN    = 2'd1,
    SEL_DEL   = 2'd2,
    SEL_SPACE = 2'd3
  } byte_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      emit;
    logic      eol;
    byte_sel_t sel;
    logic      last;
    logic      col_inc;
    logic      col_clr;
    logic      cr_set;
    logic      cr_clr;
    logic      z_set;
    logic      z_clr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic      eof;
    byte_cls_t cls;
    logic      cr_pend;
    logic      z_pend;
    logic      reach;
    logic      tab_end;
    logic      col_nz;
    logic      out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/tln_dp.sv =====
`default_nettype none
`include "text_line_normalizer_macros.svh"

module tln_dp #(
  parameter int TAB_STOP = 4,
  parameter int MAX_LINE = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tln_pkg::cmd_t                cmd,
  output tln_pkg::status_t             sts,
  input  logic [tln_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_eof,
  input  logic                         cfg_we,
  input  logic [tln_pkg::LIMIT_W-1:0]  cfg_wdata,
  output logic [tln_pkg::LIMIT_W-1:0]  line_limit,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tln_pkg::BYTE_W-1:0]   m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast
);
  import tln_pkg::*;

  localparam int PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(TAB_STOP - 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(MAX_LINE - 2);

  logic [BYTE_W-1:0]  byte_q;
  logic               eof_q;
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   col_inc;
  logic [PH_W-1:0]    phase;
  logic               cr_pend;
  logic               z_pend;
  logic [BYTE_W-1:0]  out_byte;
  byte_cls_t          cls;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      eof_q  <= in_eof;
    end
  end

  // Line limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      line_limit <= cfg_wdata;
    end
  end

  // Classify the held byte
  always_comb begin
    if (byte_q >= CHAR_SPACE)   cls = CLS_PRINT;
    else if (byte_q == CHAR_TAB) cls = CLS_TAB;
    else if (byte_q == CHAR_CR)  cls = CLS_CR;
    else if (byte_q == CHAR_LF)  cls = CLS_LF;
    else if (byte_q == CHAR_SUB) cls = CLS_SUB;
    else                         cls = CLS_CTRL;
  end

  assign col_inc = col + COL_W'(1);

  // Column and position within the tab stop
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      phase <= '0;
    end else if (cmd.col_clr) begin
      col   <= '0;
      phase <= '0;
    end else if (cmd.col_inc) begin
      col   <= col_inc;
      phase <= (phase == PH_LAST) ? '0 : PH_W'(phase + 1'b1);
    end
  end

  // Pending CR and ^Z flags; a set wins over a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pend <= 1'b0;
      z_pend  <= 1'b0;
    end else begin
      if (cmd.cr_set)      cr_pend <= 1'b1;
      else if (cmd.cr_clr) cr_pend <= 1'b0;
      if (cmd.z_set)       z_pend  <= 1'b1;
      else if (cmd.z_clr)  z_pend  <= 1'b0;
    end
  end

  // Pick the emitted byte
  always_comb begin
    unique case (cmd.sel)
      SEL_IN:    out_byte = byte_q;
      SEL_DEL:   out_byte = CHAR_DEL;
      SEL_SPACE: out_byte = CHAR_SPACE;
      default:   out_byte = CHAR_NUL;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= out_byte;
      m_tuser <= cmd.eol ? KIND_EOL : KIND_CHAR;
      m_tlast <= cmd.last;
    end
  end

  // Status to the controller
  always_comb begin
    sts.eof      = eof_q;
    sts.cls      = cls;
    sts.cr_pend  = cr_pend;
    sts.z_pend   = z_pend;
    sts.reach    = col_inc >= {{(COL_W-LIMIT_W){1'b0}}, line_limit};
    sts.tab_end  = phase == PH_LAST;
    sts.col_nz   = col != '0;
    sts.out_free = !m_tvalid || m_tready;
  end

  `TLN_ASSERT_NEXT(a_col_clear, clk, rst, cmd.col_clr, (col == '0) && (phase == '0), "column not cleared")
  `TLN_ASSERT_IMPLY(a_flags_excl, clk, rst, cr_pend, !z_pend, "CR and ^Z pending together")
  `TLN_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, m_tvalid, "emitted item not presented")

endmodule

`default_nettype wire

// ===== src/tln_ctrl.sv =====
`default_nettype none
`include "text_line_normalizer_macros.svh"

module tln_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  tln_pkg::status_t sts,
  output tln_pkg::cmd_t    cmd
);
  import tln_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_ZEOL   = 6'b000100,
    ST_MAIN   = 6'b001000,
    ST_TAB    = 6'b010000,
    ST_LIMEOL = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   main;

  assign s_tready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the results of one item
  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_NONE;
    state_next = state;
    main       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.out_free) begin
          if (sts.eof) begin
            // end of text: close an open line, drop everything pending
            cmd.col_clr = 1'b1;
            cmd.cr_clr  = 1'b1;
            cmd.z_clr   = 1'b1;
            if (sts.z_pend || sts.col_nz) begin
              cmd.emit = 1'b1;
              cmd.eol  = 1'b1;
              cmd.last = 1'b1;
            end
            state_next = ST_IDLE;
          end else if (sts.cr_pend && sts.cls == CLS_LF) begin
            // LF after CR: swallow
            cmd.cr_clr = 1'b1;
            state_next = ST_IDLE;
          end else if (sts.z_pend) begin
            // ^Z not at end of text: show it first
            cmd.cr_clr  = 1'b1;
            cmd.z_clr   = 1'b1;
            cmd.emit    = 1'b1;
            cmd.sel     = SEL_DEL;
            cmd.col_inc = 1'b1;
            cmd.last    = !sts.reach && sts.cls == CLS_SUB;
            state_next  = sts.reach ? ST_ZEOL : ST_MAIN;
          end else begin
            cmd.cr_clr = 1'b1;
            main       = 1'b1;
          end
        end
      end
      ST_ZEOL: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.eol     = 1'b1;
          cmd.col_clr = 1'b1;
          cmd.last    = sts.cls == CLS_SUB;
          state_next  = ST_MAIN;
        end
      end
      ST_MAIN, ST_TAB: begin
        if (sts.out_free) begin
          main = 1'b1;
        end
      end
      ST_LIMEOL: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.eol     = 1'b1;
          cmd.col_clr = 1'b1;
          cmd.last    = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Handle the byte itself
    if (main) begin
      unique case (sts.cls)
        CLS_PRINT, CLS_CTRL: begin
          cmd.emit    = 1'b1;
          cmd.sel     = (sts.cls == CLS_PRINT) ? SEL_IN : SEL_DEL;
          cmd.col_inc = 1'b1;
          cmd.last    = !sts.reach;
          state_next  = sts.reach ? ST_LIMEOL : ST_IDLE;
        end
        CLS_TAB: begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_SPACE;
          cmd.col_inc = 1'b1;
          if (sts.tab_end) begin
            cmd.last   = !sts.reach;
            state_next = sts.reach ? ST_LIMEOL : ST_IDLE;
          end else begin
            state_next = ST_TAB;
          end
        end
        CLS_CR, CLS_LF: begin
          cmd.emit    = 1'b1;
          cmd.eol     = 1'b1;
          cmd.col_clr = 1'b1;
          cmd.last    = 1'b1;
          cmd.cr_set  = sts.cls == CLS_CR;
          state_next  = ST_IDLE;
        end
        CLS_SUB: begin
          // defer: dropped at end of text, shown otherwise
          cmd.z_set  = 1'b1;
          state_next = ST_IDLE;
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  `TLN_ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit, sts.out_free, "emit into a full output register")
  `TLN_ASSERT_IMPLY(a_idle_quiet, clk, rst, state == ST_IDLE, !cmd.emit, "emit while idle")

endmodule

`default_nettype wire

// ===== src/text_line_normalizer.sv =====
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[7:0] in_byte, tlast end_of_file
// m_*       out  tvalid/tready      tdata[7:0] out_byte, tuser kind, tlast last
// apb       in   psel/penable/pwrite line_limit at byte address 0
//
// An item is taken only while idle; the controller then issues its results
// in turn: up to 2 for a plain byte, up to TAB_STOP + 1 for a tab, and up
// to two more when a ^Z is shown first, before it takes the next item.
// The output register holds one result; while it is full and m_tready is
// low the controller waits in place. rst is synchronous and sets line_limit
// to MAX_LINE-2 and clears the column and pending CR and ^Z flags.
`default_nettype none

module text_line_normalizer #(
  parameter int TAB_STOP = 4,
  parameter int MAX_LINE = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tln_pkg::*;

  cmd_t               cmd;
  status_t            sts;
  logic               cfg_we;
  logic [LIMIT_W-1:0] line_limit;

  // Register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LINE_LIMIT);
  assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {{(32-LIMIT_W){1'b0}}, line_limit} : '0;

  tln_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tln_dp #(
    .TAB_STOP (TAB_STOP),
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (s_tdata),
    .in_eof     (s_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[LIMIT_W-1:0]),
    .line_limit (line_limit),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/tb_text_line_normalizer.sv =====
`default_nettype none

module tb_text_line_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  import tln_pkg::*;

  localparam int TAB_STOP = 4;
  localparam int MAX_LINE = 512;
  localparam logic [2:0] LINE_LIMIT_ADDR = {REG_LINE_LIMIT, 2'b00};
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTS = 40;

  // One display result: character or end-of-line marker
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } disp_res_t;

  // Directed row; r0/r1 are {kind, byte} of the typed-in results
  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       typed;
    logic [1:0] n;
    logic [8:0] r0;
    logic [8:0] r1;
  } dir_row_t;

  localparam logic [8:0] EOL_RES = {KIND_EOL, CHAR_NUL};

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  text_line_normalizer #(
    .TAB_STOP(TAB_STOP),
    .MAX_LINE(MAX_LINE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),   // [7:0] in_byte
    .s_tlast(s_tlast),   // end_of_file
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),   // [7:0] out_byte
    .m_tuser(m_tuser),   // [0] kind
    .m_tlast(m_tlast),   // last
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [9:0] col;
  logic       cr_pend;
  logic       z_pend;
  logic [8:0] limit;

  disp_res_t step_res[$];
  disp_res_t disp_q[$];
  dir_row_t  dir_rows[$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int eols_checked = 0;
  int cycle_count = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 72;
  logic hold_req = 1'b0;

  function automatic void note_mismatch(string what, int expv, int actv);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, expv, actv);
  endfunction

  function automatic void put_res(logic kind, logic [7:0] ch);
    disp_res_t r;
    r.kind = kind;
    r.ch = ch;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void end_line();
    put_res(KIND_EOL, CHAR_NUL);
    col = '0;
  endfunction

  function automatic void check_limit();
    if (col >= {1'b0, limit})
      end_line();
  endfunction

  function automatic void put_char(logic [7:0] ch);
    put_res(KIND_CHAR, ch);
    col = col + 10'd1;
    check_limit();
  endfunction

  // Work out the display results of one accepted item and queue them
  function automatic void normalize_item(logic [7:0] b, logic eof);
    logic swallow;
    step_res.delete();
    if (eof) begin
      if (z_pend || col != 0)
        end_line();
      col = '0;
      cr_pend = 1'b0;
      z_pend = 1'b0;
    end else begin
      swallow = 1'b0;
      if (cr_pend) begin
        cr_pend = 1'b0;
        if (b == CHAR_LF)
          swallow = 1'b1;
      end
      if (!swallow) begin
        // a ^Z not followed by end of file shows as DEL
        if (z_pend) begin
          z_pend = 1'b0;
          put_char(CHAR_DEL);
        end
        if (b >= CHAR_SPACE) begin
          put_char(b);
        end else if (b == CHAR_TAB) begin
          // no limit check until the tab stop is reached
          do begin
            put_res(KIND_CHAR, CHAR_SPACE);
            col = col + 10'd1;
          end while ((col % TAB_STOP) != 0);
          check_limit();
        end else if (b == CHAR_CR) begin
          end_line();
          cr_pend = 1'b1;
        end else if (b == CHAR_LF) begin
          end_line();
        end else if (b == CHAR_SUB) begin
          z_pend = 1'b1;
        end else begin
          put_char(CHAR_DEL);
        end
      end
    end
    if (step_res.size() > 0)
      step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i])
      disp_q.push_back(step_res[i]);
  endfunction

  // Offer one item, with random idle cycles in front; ends on a falling edge
  task automatic send_item(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = eof;
    do @(posedge clk); while (!s_tready);
    normalize_item(b, eof);
    items_sent++;
    @(negedge clk);
  endtask

  // Random text: mostly printable bytes with line breaks, tabs and controls
  task automatic send_random_text(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 6)
        send_item(8'($urandom_range(255)), 1'b1);
      else if (r < 18)
        send_item(CHAR_TAB, 1'b0);
      else if (r < 25)
        send_item(CHAR_CR, 1'b0);
      else if (r < 32)
        send_item(CHAR_LF, 1'b0);
      else if (r < 38)
        send_item(CHAR_SUB, 1'b0);
      else if (r < 46)
        send_item(8'($urandom_range(31)), 1'b0);
      else
        send_item(8'($urandom_range(255, 32)), 1'b0);
    end
  endtask

  // Drop valid, wait out every expected result and the block's own latency
  task automatic settle();
    s_tvalid = 1'b0;
    while (disp_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write line_limit, then read it back
  task automatic set_line_limit(input logic [8:0] lim);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = LINE_LIMIT_ADDR;
    pwdata = {23'd0, lim};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    limit = lim;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {23'd0, lim})
      note_mismatch("line_limit readback", {23'd0, lim}, prdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic add_row(input logic [7:0] b, input logic eof, input logic typed,
                         input logic [1:0] n, input logic [8:0] r0, input logic [8:0] r1);
    dir_row_t row;
    row.b = b;
    row.eof = eof;
    row.typed = typed;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    dir_rows.push_back(row);
  endtask

  // Receiver: random stalls, plus one long hold counted here
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    disp_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (disp_q.size() == 0) begin
        note_mismatch("unexpected result {kind,byte}", 0, {m_tuser, m_tdata});
      end else begin
        want = disp_q.pop_front();
        if (m_tuser !== want.kind)
          note_mismatch("kind", want.kind, m_tuser);
        if (m_tdata !== want.ch)
          note_mismatch("out_byte", want.ch, m_tdata);
        if (m_tlast !== want.last)
          note_mismatch("last", want.last, m_tlast);
        results_checked++;
        if (want.kind == KIND_EOL)
          eols_checked++;
      end
    end
  end

  // Hard limit on run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_row_t row;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    col = '0;
    cr_pend = 1'b0;
    z_pend = 1'b0;
    limit = 9'(MAX_LINE - 2);
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed table at the reset limit
    add_row(8'h41,    1'b0, 1'b1, 2'd1, {KIND_CHAR, 8'h41}, '0);
    add_row(8'h20,    1'b0, 1'b1, 2'd1, {KIND_CHAR, 8'h20}, '0);
    add_row(8'hFF,    1'b0, 1'b1, 2'd1, {KIND_CHAR, 8'hFF}, '0);
    add_row(8'h80,    1'b0, 1'b1, 2'd1, {KIND_CHAR, 8'h80}, '0);
    add_row(CHAR_NUL, 1'b0, 1'b1, 2'd1, {KIND_CHAR, CHAR_DEL}, '0);
    add_row(8'h1F,    1'b0, 1'b1, 2'd1, {KIND_CHAR, CHAR_DEL}, '0);
    add_row(CHAR_TAB, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CHAR_CR,  1'b0, 1'b1, 2'd1, EOL_RES, '0);
    add_row(CHAR_LF,  1'b0, 1'b1, 2'd0, '0, '0);
    add_row(CHAR_LF,  1'b0, 1'b1, 2'd1, EOL_RES, '0);
    add_row(CHAR_CR,  1'b0, 1'b1, 2'd1, EOL_RES, '0);
    add_row(8'h41,    1'b0, 1'b1, 2'd1, {KIND_CHAR, 8'h41}, '0);
    add_row(CHAR_SUB, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h42,    1'b0, 1'b1, 2'd2, {KIND_CHAR, CHAR_DEL}, {KIND_CHAR, 8'h42});
    add_row(CHAR_SUB, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'hA5,    1'b1, 1'b1, 2'd1, EOL_RES, '0);
    add_row(8'h5A,    1'b1, 1'b1, 2'd0, '0, '0);
    add_row(CHAR_SUB, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(8'h00,    1'b1, 1'b1, 2'd1, EOL_RES, '0);
    add_row(CHAR_TAB, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CHAR_SUB, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(CHAR_TAB, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CHAR_CR,  1'b0, 1'b1, 2'd1, EOL_RES, '0);
    add_row(8'hFF,    1'b1, 1'b1, 2'd0, '0, '0);
    add_row(CHAR_DEL, 1'b0, 1'b1, 2'd1, {KIND_CHAR, CHAR_DEL}, '0);
    add_row(8'h00,    1'b1, 1'b1, 2'd1, EOL_RES, '0);

    // Walk the table; typed rows must also agree with the predictor
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.b, row.eof);
      if (row.typed) begin
        if (step_res.size() != row.n)
          note_mismatch("directed result count", row.n, step_res.size());
        else if (row.n >= 1 && {step_res[0].kind, step_res[0].ch} != row.r0)
          note_mismatch("directed first result", row.r0, {step_res[0].kind, step_res[0].ch});
        else if (row.n == 2 && {step_res[1].kind, step_res[1].ch} != row.r1)
          note_mismatch("directed second result", row.r1, {step_res[1].kind, step_res[1].ch});
      end
    end

    // Limit 4; ^Z then a tab at the limit gives the longest burst
    settle();
    set_line_limit(9'd4);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b0);
    send_item(8'h63, 1'b0);
    send_item(CHAR_SUB, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_random_text(30);

    // Limit zero ends a line after every character; hold the output meanwhile
    settle();
    set_line_limit(9'd0);
    send_random_text(30);
    hold_req = 1'b1;
    send_random_text(30);

    send_idle_pct = 72;
    recv_idle_pct = 23;

    // Small limit where tabs run past it; pause the sender until drained
    settle();
    set_line_limit(9'd6);
    send_random_text(30);
    settle();
    send_random_text(30);

    settle();
    set_line_limit(9'd37);
    send_random_text(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Highest limit: a run of tabs carries the column past it
    settle();
    set_line_limit(9'd510);
    repeat (130) send_item(CHAR_TAB, 1'b0);
    send_random_text(25);
    send_item(8'h00, 1'b1);

    settle();
    $display("Sent %0d items over line limits 510, 4, 0, 6, 37 and 510", items_sent);
    $display("Checked %0d results, %0d of them end-of-line markers",
             results_checked, eols_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== text_line_normalizer.f =====
+incdir+src
src/tln_pkg.sv
src/tln_dp.sv
src/tln_ctrl.sv
src/text_line_normalizer.sv
verif/tb_text_line_normalizer.sv
